// File: rtl/hfs_pkg.sv
package hfs_pkg;

    localparam int FORCE_WIDTH = 24;
    localparam int VEC_W       = FORCE_WIDTH + 2;
    localparam int MUL_W       = 2 * VEC_W;
    localparam int SUM_W       = MUL_W - 1;
    localparam int GAIN_W      = 17;
    localparam int LIM_W       = 23;
    localparam int RAMP_W      = 17;
    localparam int CFG_W       = 23;
    localparam int CFG_IDX_W   = 2;
    localparam int DCNT_W      = $clog2(MUL_W + 1);

    localparam logic [GAIN_W-1:0] Q16_ONE  = GAIN_W'(65536);
    localparam logic [RAMP_W-1:0] RAMP_MAX = RAMP_W'(131071);
    localparam logic [15:0]       Q16_HALF = 16'd32768;

    localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(2521);
    localparam logic [LIM_W-1:0]  STEP_RST = LIM_W'(16384);
    localparam logic [LIM_W-1:0]  NORM_RST = LIM_W'(983040);
    localparam logic [GAIN_W-1:0] RSTEP_RST = GAIN_W'(819);

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FORCE_NORM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP      = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RAMP_MUL,
        ST_TGT_MUL,
        ST_GAIN_MUL,
        ST_SQ_MUL,
        ST_LIM_MUL,
        ST_SQRT,
        ST_DIV_MUL,
        ST_DIV,
        ST_UPDATE,
        ST_OUT
    } t_state;

    function automatic logic [VEC_W-1:0] abs_vec(input logic signed [VEC_W-1:0] v);
        return v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
    endfunction

    function automatic logic signed [FORCE_WIDTH-1:0] sat_force(
        input logic signed [VEC_W:0] v);
        logic signed [VEC_W:0] hi;
        logic signed [VEC_W:0] lo;
        hi = (VEC_W+1)'((1 <<< (FORCE_WIDTH - 1)) - 1);
        lo = -hi - (VEC_W+1)'(1);
        if (v > hi) begin
            return FORCE_WIDTH'(hi);
        end else if (v < lo) begin
            return FORCE_WIDTH'(lo);
        end
        return FORCE_WIDTH'(v);
    endfunction

endpackage

// File: rtl/haptic_force_shaper.sv
// Haptic force shaper: ramp-in, first-order low-pass and vector slew limit on a
// 3-axis Q8.16 force, then a vector norm ceiling. One request at a time; an
// inactive request presents zeros the cycle after it is taken, an active one
// takes longer depending on operand sizes and whether the limits cut in. The
// time is set by the single shift-add multiplier (one operand bit per cycle,
// stops early on small operands), the two-bits-per-cycle square root and the
// restoring divider (per axis after its multiply, when the slew or norm limit
// cuts in). Configuration is accepted any time the block is idle.
module haptic_force_shaper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_contact_active,
    input  logic signed [hfs_pkg::FORCE_WIDTH-1:0] i_target_x,
    input  logic signed [hfs_pkg::FORCE_WIDTH-1:0] i_target_y,
    input  logic signed [hfs_pkg::FORCE_WIDTH-1:0] i_target_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [hfs_pkg::FORCE_WIDTH-1:0] o_force_x,
    output logic signed [hfs_pkg::FORCE_WIDTH-1:0] o_force_y,
    output logic signed [hfs_pkg::FORCE_WIDTH-1:0] o_force_z,
    output logic                                o_slew_limited,
    output logic                                o_norm_clamped,
    input  logic                                i_cfg_wr_en,
    input  logic [hfs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hfs_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int FW = hfs_pkg::FORCE_WIDTH;
    localparam int VW = hfs_pkg::VEC_W;
    localparam int MW = hfs_pkg::MUL_W;
    localparam int SW = hfs_pkg::SUM_W;

    hfs_pkg::t_state r_state, n_state;

    logic [hfs_pkg::GAIN_W-1:0] r_gain, r_rstep;
    logic [hfs_pkg::LIM_W-1:0]  r_mstep, r_mnorm;

    logic signed [FW-1:0] r_filt [3], n_filt [3];
    logic signed [FW-1:0] r_tgt  [3], n_tgt  [3];
    logic signed [VW-1:0] r_v    [3], n_v    [3];
    logic                 r_was_active, n_was_active;
    logic [hfs_pkg::RAMP_W-1:0] r_ramp_count, n_ramp_count;
    logic [hfs_pkg::GAIN_W-1:0] r_ramp, n_ramp;
    logic [1:0]           r_ax, n_ax;
    logic                 r_pass, n_pass;
    logic                 r_exc, n_exc;
    logic [hfs_pkg::LIM_W-1:0] r_lim, n_lim;

    logic [MW-1:0]        r_ma, n_ma, r_acc, n_acc;
    logic [VW-1:0]        r_mb, n_mb;
    logic [SW-1:0]        r_sum, n_sum;
    logic [SW-1:0]        r_rem, n_rem, r_res, n_res, r_bit, n_bit;
    logic [VW-1:0]        r_norm, n_norm;
    logic [MW-1:0]        r_dq, n_dq;
    logic [VW-1:0]        r_drem, n_drem;
    logic [hfs_pkg::DCNT_W-1:0] r_dcnt, n_dcnt;
    logic                 r_dsign, n_dsign;

    logic signed [FW-1:0] r_fx, r_fy, r_fz, n_fx, n_fy, n_fz;
    logic                 r_slew, r_clamp, n_slew, n_clamp;

    logic in_acc, out_acc, mul_done, sqrt_done, div_done;

    assign in_acc    = i_valid && !o_stall;
    assign out_acc   = o_valid && !i_stall;
    assign mul_done  = (r_mb == '0);
    assign sqrt_done = (r_bit == '0);
    assign div_done  = (r_dcnt == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hfs_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = i_contact_active ? hfs_pkg::ST_RAMP_MUL : hfs_pkg::ST_OUT;
                end
            end
            hfs_pkg::ST_RAMP_MUL: begin
                if (mul_done) n_state = hfs_pkg::ST_TGT_MUL;
            end
            hfs_pkg::ST_TGT_MUL: begin
                if (mul_done) n_state = hfs_pkg::ST_GAIN_MUL;
            end
            hfs_pkg::ST_GAIN_MUL: begin
                if (mul_done) begin
                    n_state = (r_ax == 2'd2) ? hfs_pkg::ST_SQ_MUL : hfs_pkg::ST_TGT_MUL;
                end
            end
            hfs_pkg::ST_SQ_MUL: begin
                if (mul_done && r_ax == 2'd2) n_state = hfs_pkg::ST_LIM_MUL;
            end
            hfs_pkg::ST_LIM_MUL: begin
                if (mul_done) begin
                    n_state = (MW'(r_sum) > r_acc) ? hfs_pkg::ST_SQRT : hfs_pkg::ST_UPDATE;
                end
            end
            hfs_pkg::ST_SQRT: begin
                if (sqrt_done) n_state = hfs_pkg::ST_DIV_MUL;
            end
            hfs_pkg::ST_DIV_MUL: begin
                if (mul_done) n_state = hfs_pkg::ST_DIV;
            end
            hfs_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = (r_ax == 2'd2) ? hfs_pkg::ST_UPDATE : hfs_pkg::ST_DIV_MUL;
                end
            end
            hfs_pkg::ST_UPDATE: begin
                n_state = r_pass ? hfs_pkg::ST_OUT : hfs_pkg::ST_SQ_MUL;
            end
            hfs_pkg::ST_OUT: begin
                if (!i_stall) n_state = hfs_pkg::ST_IDLE;
            end
            default: n_state = hfs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != hfs_pkg::ST_IDLE);
        o_valid = (r_state == hfs_pkg::ST_OUT);
    end

    assign o_force_x      = r_fx;
    assign o_force_y      = r_fy;
    assign o_force_z      = r_fz;
    assign o_slew_limited = r_slew;
    assign o_norm_clamped = r_clamp;

    always_comb begin
        logic [hfs_pkg::RAMP_W-1:0] cnt;
        logic [hfs_pkg::GAIN_W-1:0] gsat;
        logic [MW-1:0]              rnd;
        logic signed [VW-1:0]       rv;
        logic signed [VW-1:0]       diff;
        logic [SW:0]                trial;
        logic [VW:0]                dt;
        logic                       ge;
        logic [VW-1:0]              q;
        logic signed [VW:0]         fs;

        n_filt = r_filt;   n_tgt = r_tgt;   n_v = r_v;
        n_was_active = r_was_active;  n_ramp_count = r_ramp_count;
        n_ramp = r_ramp;   n_ax = r_ax;     n_pass = r_pass;
        n_exc = r_exc;     n_lim = r_lim;   n_sum = r_sum;
        n_rem = r_rem;     n_res = r_res;   n_bit = r_bit;
        n_norm = r_norm;   n_dq = r_dq;     n_drem = r_drem;
        n_dcnt = r_dcnt;   n_dsign = r_dsign;
        n_fx = r_fx;  n_fy = r_fy;  n_fz = r_fz;
        n_slew = r_slew;   n_clamp = r_clamp;

        cnt   = '0;
        gsat  = (r_gain > hfs_pkg::Q16_ONE) ? hfs_pkg::Q16_ONE : r_gain;
        rnd   = r_acc + MW'(hfs_pkg::Q16_HALF);
        rv    = '0;
        diff  = '0;
        trial = '0;
        dt    = '0;
        ge    = 1'b0;
        q     = '0;
        fs    = '0;

        n_ma  = r_ma << 1;
        n_mb  = r_mb >> 1;
        n_acc = r_mb[0] ? r_acc + r_ma : r_acc;

        case (r_state)
            hfs_pkg::ST_IDLE: begin
                n_ma = r_ma;  n_mb = r_mb;  n_acc = r_acc;
                if (in_acc) begin
                    n_tgt[0] = i_target_x;
                    n_tgt[1] = i_target_y;
                    n_tgt[2] = i_target_z;
                    if (!i_contact_active) begin
                        for (int i = 0; i < 3; i++) n_filt[i] = '0;
                        n_was_active = 1'b0;
                        n_ramp_count = '0;
                        n_fx = '0;  n_fy = '0;  n_fz = '0;
                        n_slew = 1'b0;  n_clamp = 1'b0;
                    end else begin
                        cnt = r_was_active ? r_ramp_count : '0;
                        n_was_active = 1'b1;
                        n_ramp_count = (cnt < hfs_pkg::RAMP_MAX) ? cnt + 1'b1 : cnt;
                        n_ma  = MW'(cnt);
                        n_mb  = VW'(r_rstep);
                        n_acc = '0;
                    end
                end
            end
            hfs_pkg::ST_RAMP_MUL: begin
                if (mul_done) begin
                    n_ramp = (r_acc > MW'(hfs_pkg::Q16_ONE)) ? hfs_pkg::Q16_ONE
                                                             : hfs_pkg::GAIN_W'(r_acc);
                    n_ax  = 2'd0;
                    n_ma  = MW'(hfs_pkg::abs_vec(VW'(r_tgt[0])));
                    n_mb  = VW'(n_ramp);
                    n_acc = '0;
                end
            end
            hfs_pkg::ST_TGT_MUL: begin
                if (mul_done) begin
                    rv    = r_tgt[r_ax][FW-1] ? -VW'(rnd[MW-1:16]) : VW'(rnd[MW-1:16]);
                    diff  = rv - VW'(r_filt[r_ax]);
                    n_dsign = diff[VW-1];
                    n_ma  = MW'(hfs_pkg::abs_vec(diff));
                    n_mb  = VW'(gsat);
                    n_acc = '0;
                end
            end
            hfs_pkg::ST_GAIN_MUL: begin
                if (mul_done) begin
                    n_v[r_ax] = r_dsign ? -VW'(rnd[MW-1:16]) : VW'(rnd[MW-1:16]);
                    if (r_ax == 2'd2) begin
                        n_ax   = 2'd0;
                        n_pass = 1'b0;
                        n_lim  = r_mstep;
                        n_sum  = '0;
                        n_ma   = MW'(hfs_pkg::abs_vec(n_v[0]));
                        n_mb   = hfs_pkg::abs_vec(n_v[0]);
                    end else begin
                        n_ax = r_ax + 2'd1;
                        n_ma = MW'(hfs_pkg::abs_vec(VW'(r_tgt[n_ax])));
                        n_mb = VW'(r_ramp);
                    end
                    n_acc = '0;
                end
            end
            hfs_pkg::ST_SQ_MUL: begin
                if (mul_done) begin
                    n_sum = r_sum + SW'(r_acc);
                    if (r_ax == 2'd2) begin
                        n_ma = MW'(r_lim);
                        n_mb = VW'(r_lim);
                    end else begin
                        n_ax = r_ax + 2'd1;
                        n_ma = MW'(hfs_pkg::abs_vec(r_v[n_ax]));
                        n_mb = hfs_pkg::abs_vec(r_v[n_ax]);
                    end
                    n_acc = '0;
                end
            end
            hfs_pkg::ST_LIM_MUL: begin
                if (mul_done) begin
                    n_exc = (MW'(r_sum) > r_acc);
                    n_rem = r_sum;
                    n_res = '0;
                    n_bit = SW'(1) << (SW - 1);
                end
            end
            hfs_pkg::ST_SQRT: begin
                if (!sqrt_done) begin
                    trial = (SW+1)'(r_res) + (SW+1)'(r_bit);
                    if ((SW+1)'(r_rem) >= trial) begin
                        n_rem = r_rem - SW'(trial);
                        n_res = (r_res >> 1) + r_bit;
                    end else begin
                        n_res = r_res >> 1;
                    end
                    n_bit = r_bit >> 2;
                end else begin
                    n_norm = VW'(r_res);
                    n_ax   = 2'd0;
                    n_ma   = MW'(hfs_pkg::abs_vec(r_v[0]));
                    n_mb   = VW'(r_lim);
                    n_acc  = '0;
                end
            end
            hfs_pkg::ST_DIV_MUL: begin
                if (mul_done) begin
                    n_dq    = r_acc + MW'(r_norm >> 1);
                    n_drem  = '0;
                    n_dcnt  = hfs_pkg::DCNT_W'(MW);
                    n_dsign = r_v[r_ax][VW-1];
                end
            end
            hfs_pkg::ST_DIV: begin
                if (!div_done) begin
                    dt = {r_drem, r_dq[MW-1]};
                    ge = (dt >= (VW+1)'(r_norm));
                    n_drem = ge ? VW'(dt - (VW+1)'(r_norm)) : VW'(dt);
                    n_dq   = {r_dq[MW-2:0], ge};
                    n_dcnt = r_dcnt - 1'b1;
                end else begin
                    q = VW'(r_dq);
                    n_v[r_ax] = r_dsign ? -q : q;
                    if (r_ax != 2'd2) begin
                        n_ax  = r_ax + 2'd1;
                        n_ma  = MW'(hfs_pkg::abs_vec(r_v[n_ax]));
                        n_mb  = VW'(r_lim);
                        n_acc = '0;
                    end
                end
            end
            hfs_pkg::ST_UPDATE: begin
                if (!r_pass) begin
                    n_slew = r_exc;
                    for (int i = 0; i < 3; i++) begin
                        fs = (VW+1)'(r_filt[i]) + (VW+1)'(r_v[i]);
                        n_filt[i] = hfs_pkg::sat_force(fs);
                        n_v[i]    = VW'(n_filt[i]);
                    end
                    n_pass = 1'b1;
                    n_lim  = r_mnorm;
                    n_sum  = '0;
                    n_ax   = 2'd0;
                    n_ma   = MW'(hfs_pkg::abs_vec(n_v[0]));
                    n_mb   = hfs_pkg::abs_vec(n_v[0]);
                    n_acc  = '0;
                end else begin
                    n_clamp = r_exc;
                    n_fx = hfs_pkg::sat_force((VW+1)'(r_v[0]));
                    n_fy = hfs_pkg::sat_force((VW+1)'(r_v[1]));
                    n_fz = hfs_pkg::sat_force((VW+1)'(r_v[2]));
                end
            end
            default: begin
                n_ma = r_ma;  n_mb = r_mb;  n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hfs_pkg::ST_IDLE;
            r_gain       <= hfs_pkg::GAIN_RST;
            r_mstep      <= hfs_pkg::STEP_RST;
            r_mnorm      <= hfs_pkg::NORM_RST;
            r_rstep      <= hfs_pkg::RSTEP_RST;
            r_was_active <= 1'b0;
            r_ramp_count <= '0;
            r_mb         <= '0;
            r_bit        <= '0;
            r_dcnt       <= '0;
            for (int i = 0; i < 3; i++) r_filt[i] <= '0;
        end else begin
            r_state      <= n_state;
            r_was_active <= n_was_active;
            r_ramp_count <= n_ramp_count;
            r_mb         <= n_mb;
            r_bit        <= n_bit;
            r_dcnt       <= n_dcnt;
            r_filt       <= n_filt;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    hfs_pkg::REG_FILTER_GAIN:    r_gain  <= i_cfg_data[hfs_pkg::GAIN_W-1:0];
                    hfs_pkg::REG_MAX_STEP:       r_mstep <= i_cfg_data;
                    hfs_pkg::REG_MAX_FORCE_NORM: r_mnorm <= i_cfg_data;
                    hfs_pkg::REG_RAMP_STEP:      r_rstep <= i_cfg_data[hfs_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt   <= n_tgt;    r_v    <= n_v;     r_ramp <= n_ramp;
        r_ax    <= n_ax;     r_pass <= n_pass;  r_exc  <= n_exc;
        r_lim   <= n_lim;    r_ma   <= n_ma;    r_acc  <= n_acc;
        r_sum   <= n_sum;    r_rem  <= n_rem;   r_res  <= n_res;
        r_norm  <= n_norm;   r_dq   <= n_dq;    r_drem <= n_drem;
        r_dsign <= n_dsign;
        r_fx    <= n_fx;     r_fy   <= n_fy;    r_fz   <= n_fz;
        r_slew  <= n_slew;   r_clamp <= n_clamp;
    end

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != hfs_pkg::ST_IDLE)
        else $error("request accepted but sequencer stayed idle");

    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hfs_pkg::ST_SQRT |-> $onehot0(r_bit))
        else $error("root trial bit not one-hot");

    a_ramp_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_was_active |-> r_ramp_count == '0)
        else $error("ramp count live without contact");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hfs_pkg::ST_DIV |-> r_drem < r_norm)
        else $error("divider remainder out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |=> r_state == hfs_pkg::ST_IDLE)
        else $error("result taken but block not idle");

endmodule
